[design/vfcm_pkg.sv]
// Shared types, codes and geometry tables for the voxel face-culling mesher.
// No dependencies; every module of the block but vfcm_ram imports this package.
`default_nettype none
package vfcm_pkg;

    // Input action codes.
    localparam logic [1:0] ACT_WVOX = 2'd0;
    localparam logic [1:0] ACT_WATL = 2'd1;
    localparam logic [1:0] ACT_MESH = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_ORIGIN_X = 1'b0;
    localparam logic CFG_ORIGIN_Z = 1'b1;

    localparam int NUM_FACES = 6;

    // Texture tile and inset in Q16.
    localparam logic [16:0] TEX_LO = 17'd250;
    localparam logic [16:0] TEX_HI = 17'd3846;

    typedef enum logic [1:0] {
        OP_NOP,
        OP_VOX,
        OP_ATL,
        OP_MESH
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [3:0]  x;
        logic [7:0]  y;
        logic [3:0]  z;
        logic [7:0]  id;
        logic [2:0]  face;
        logic [15:0] u;
        logic [15:0] v;
    } t_item;

    typedef struct packed {
        logic clearing;
        logic pop_ready;
    } t_back_stat;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CENTER,
        ST_NBR,
        ST_EMIT
    } t_state;

    // Quad corner per face: bit 2 = x offset, bit 1 = upper height, bit 0 = z offset.
    localparam logic [2:0] FACE_CORNER [NUM_FACES][4] = '{
        '{3'b001, 3'b101, 3'b111, 3'b011},
        '{3'b100, 3'b000, 3'b010, 3'b110},
        '{3'b011, 3'b111, 3'b110, 3'b010},
        '{3'b000, 3'b100, 3'b101, 3'b001},
        '{3'b000, 3'b001, 3'b011, 3'b010},
        '{3'b101, 3'b100, 3'b110, 3'b111}
    };

    localparam logic [1:0] TRI_ORDER [6] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd2, 2'd3};

    // Texture corner selects per quad corner: high u, high v.
    localparam logic TEX_U_HI [4] = '{1'b0, 1'b1, 1'b1, 1'b0};
    localparam logic TEX_V_HI [4] = '{1'b0, 1'b0, 1'b1, 1'b1};

    // Lowest set face in a six-bit mask.
    function automatic logic [2:0] first_face(input logic [5:0] mask);
        logic [2:0] f;
        f = 3'd0;
        for (int i = NUM_FACES - 1; i >= 0; i--) begin
            if (mask[i]) f = 3'(i);
        end
        return f;
    endfunction

endpackage
`default_nettype wire

[design/vfcm_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`default_nettype none
module vfcm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (i_re) o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

[design/vfcm_front.sv]
// Front end: accepts input items, classifies them and holds them in a two-entry queue.
// Depends on vfcm_pkg.
`default_nettype none
module vfcm_front import vfcm_pkg::*; #(
    parameter int CHUNK_WIDTH  = 16,
    parameter int CHUNK_HEIGHT = 256,
    parameter int BLOCK_TYPES  = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [3:0]  i_voxel_x,
    input  wire logic [7:0]  i_voxel_y,
    input  wire logic [3:0]  i_voxel_z,
    input  wire logic [7:0]  i_block_id,
    input  wire logic [2:0]  i_face_select,
    input  wire logic [15:0] i_atlas_u,
    input  wire logic [15:0] i_atlas_v,
    input  wire t_back_stat  i_stat,
    output logic             o_item_valid,
    output t_item            o_item
);
    t_item      r_mem [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    t_item      cls;
    logic       in_chunk, id_ok, push, pop;

    always_comb begin
        in_chunk = int'(i_voxel_x) < CHUNK_WIDTH && int'(i_voxel_y) < CHUNK_HEIGHT &&
                   int'(i_voxel_z) < CHUNK_WIDTH;
        id_ok    = int'(i_block_id) < BLOCK_TYPES;
        cls.x    = i_voxel_x;
        cls.y    = i_voxel_y;
        cls.z    = i_voxel_z;
        cls.id   = i_block_id;
        cls.face = i_face_select;
        cls.u    = i_atlas_u;
        cls.v    = i_atlas_v;
        unique case (i_action)
            ACT_WVOX: cls.op = (in_chunk && id_ok) ? OP_VOX : OP_NOP;
            ACT_WATL: cls.op = (id_ok && i_face_select < 3'd6) ? OP_ATL : OP_NOP;
            ACT_MESH: cls.op = in_chunk ? OP_MESH : OP_NOP;
            default:  cls.op = OP_NOP;
        endcase
    end

    assign o_ready      = (r_count != 2'd2) && !i_stat.clearing;
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_count != 2'd0);
    assign o_item       = r_mem[r_rptr];
    assign pop          = o_item_valid && i_stat.pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wptr] <= cls;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) r_wptr <= ~r_wptr;
            if (pop)  r_rptr <= ~r_rptr;
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end
endmodule
`default_nettype wire

[design/vfcm_back.sv]
// Back end: voxel store and texture table, neighbor test sequencer and vertex output.
// Depends on vfcm_pkg and vfcm_ram.
`default_nettype none
module vfcm_back import vfcm_pkg::*; #(
    parameter int CHUNK_WIDTH  = 16,
    parameter int CHUNK_HEIGHT = 256,
    parameter int BLOCK_TYPES  = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [20:0] i_cfg_wdata,
    input  wire logic        i_item_valid,
    input  wire t_item       i_item,
    output t_back_stat       o_stat,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [25:0]      o_pos_x,
    output logic [9:0]       o_pos_y,
    output logic [25:0]      o_pos_z,
    output logic [16:0]      o_tex_u,
    output logic [16:0]      o_tex_v,
    output logic [2:0]       o_face_dir,
    output logic             o_last
);
    localparam int VDEPTH = CHUNK_WIDTH * CHUNK_WIDTH * CHUNK_HEIGHT;
    localparam int VAW    = $clog2(VDEPTH);
    localparam int ADEPTH = BLOCK_TYPES * NUM_FACES;
    localparam int AAW    = $clog2(ADEPTH);

    function automatic logic [VAW-1:0] cell_addr(input int x, input int y, input int z);
        return VAW'(x + z * CHUNK_WIDTH + y * CHUNK_WIDTH * CHUNK_WIDTH);
    endfunction

    function automatic logic [VAW-1:0] nbr_addr(input logic [3:0] x, input logic [7:0] y,
                                                input logic [3:0] z, input logic [2:0] f);
        int dx, dy, dz;
        dx = 0;
        dy = 0;
        dz = 0;
        unique case (f)
            3'd0:    dz = 1;
            3'd1:    dz = -1;
            3'd2:    dy = 1;
            3'd3:    dy = -1;
            3'd4:    dx = -1;
            default: dx = 1;
        endcase
        return cell_addr(int'(x) + dx, int'(y) + dy, int'(z) + dz);
    endfunction

    function automatic logic [AAW-1:0] atl_addr(input logic [7:0] id, input logic [2:0] f);
        return AAW'(int'(id) * NUM_FACES + int'(f));
    endfunction

    t_state r_state, n_state;
    logic [VAW-1:0] r_clr_addr;
    logic [20:0]    r_org_x, r_org_z;
    logic [3:0]     r_x, r_z;
    logic [7:0]     r_y, r_blk;
    logic [25:0]    r_wx, r_wz;
    logic [5:0]     r_nin, r_mask;
    logic [2:0]     r_cnt, r_face, r_k;

    logic           pop, out_load, nbr_air, face_done;
    logic [5:0]     mask_full, rem;
    logic           vwe, vre, awe, are;
    logic [VAW-1:0] vwaddr, vraddr;
    logic [7:0]     vwdata, vrdata;
    logic [AAW-1:0] awaddr, araddr;
    logic [31:0]    ardata;

    assign o_stat.clearing  = (r_state == ST_CLEAR);
    assign o_stat.pop_ready = (r_state == ST_IDLE);
    assign pop       = i_item_valid && (r_state == ST_IDLE);
    assign out_load  = (r_state == ST_EMIT) && (!o_valid || i_ready);
    assign nbr_air   = r_nin[r_cnt] ? (vrdata == 8'd0) : 1'b1;
    assign mask_full = r_mask | (6'(nbr_air) << r_cnt);
    assign rem       = r_mask & ~(6'd1 << r_face);
    assign face_done = (r_k == 3'd5);

    vfcm_ram #(.WIDTH(8), .DEPTH(VDEPTH)) u_voxel_ram (
        .i_clk(i_clk), .i_we(vwe), .i_waddr(vwaddr), .i_wdata(vwdata),
        .i_re(vre), .i_raddr(vraddr), .o_rdata(vrdata)
    );

    vfcm_ram #(.WIDTH(32), .DEPTH(ADEPTH)) u_atlas_ram (
        .i_clk(i_clk), .i_we(awe), .i_waddr(awaddr), .i_wdata({i_item.v, i_item.u}),
        .i_re(are), .i_raddr(araddr), .o_rdata(ardata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR:  if (r_clr_addr == VAW'(VDEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:   if (pop && i_item.op == OP_MESH) n_state = ST_CENTER;
            ST_CENTER: begin
                if (vrdata == 8'd0 || int'(vrdata) >= BLOCK_TYPES) n_state = ST_IDLE;
                else n_state = ST_NBR;
            end
            ST_NBR: begin
                if (r_cnt == 3'd5) n_state = (mask_full == 6'd0) ? ST_IDLE : ST_EMIT;
            end
            ST_EMIT:   if (out_load && face_done && rem == 6'd0) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Memory port controls.
    always_comb begin
        vwe    = 1'b0;
        vwaddr = cell_addr(int'(i_item.x), int'(i_item.y), int'(i_item.z));
        vwdata = i_item.id;
        vre    = 1'b0;
        vraddr = vwaddr;
        awe    = pop && i_item.op == OP_ATL;
        awaddr = atl_addr(i_item.id, i_item.face);
        are    = 1'b0;
        araddr = atl_addr(r_blk, first_face(mask_full));
        unique case (r_state)
            ST_CLEAR: begin
                vwe    = 1'b1;
                vwaddr = r_clr_addr;
                vwdata = 8'd0;
            end
            ST_IDLE: begin
                vwe = pop && i_item.op == OP_VOX;
                vre = pop && i_item.op == OP_MESH;
            end
            ST_CENTER: begin
                vre    = 1'b1;
                vraddr = nbr_addr(r_x, r_y, r_z, 3'd0);
            end
            ST_NBR: begin
                vre    = (r_cnt != 3'd5);
                vraddr = nbr_addr(r_x, r_y, r_z, r_cnt + 3'd1);
                are    = (r_cnt == 3'd5) && (mask_full != 6'd0);
            end
            ST_EMIT: begin
                are    = out_load && face_done && (rem != 6'd0);
                araddr = atl_addr(r_blk, first_face(rem));
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_org_x    <= '0;
            r_org_z    <= '0;
            o_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + VAW'(1);
            if (i_cfg_we && i_cfg_idx == CFG_ORIGIN_X) r_org_x <= i_cfg_wdata;
            if (i_cfg_we && i_cfg_idx == CFG_ORIGIN_Z) r_org_z <= i_cfg_wdata;
            if (out_load) o_valid <= 1'b1;
            else if (i_ready) o_valid <= 1'b0;
        end
    end

    // Mesh datapath.
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_x   <= i_item.x;
            r_y   <= i_item.y;
            r_z   <= i_item.z;
            r_wx  <= {{5{r_org_x[20]}}, r_org_x} * 26'd16 + 26'(i_item.x);
            r_wz  <= {{5{r_org_z[20]}}, r_org_z} * 26'd16 + 26'(i_item.z);
            r_nin <= {int'(i_item.x) + 1 < CHUNK_WIDTH, i_item.x != 4'd0,
                      i_item.y != 8'd0, int'(i_item.y) + 1 < CHUNK_HEIGHT,
                      i_item.z != 4'd0, int'(i_item.z) + 1 < CHUNK_WIDTH};
        end
        if (r_state == ST_CENTER) begin
            r_blk  <= vrdata;
            r_cnt  <= 3'd0;
            r_mask <= 6'd0;
        end
        if (r_state == ST_NBR) begin
            r_mask <= mask_full;
            r_cnt  <= r_cnt + 3'd1;
            r_face <= first_face(mask_full);
            r_k    <= 3'd0;
        end
        if (out_load) begin
            if (face_done) begin
                r_mask <= rem;
                r_face <= first_face(rem);
                r_k    <= 3'd0;
            end else begin
                r_k <= r_k + 3'd1;
            end
        end
    end

    // Vertex output register.
    logic [2:0] corner;
    logic [1:0] cidx;
    assign cidx   = TRI_ORDER[r_k];
    assign corner = FACE_CORNER[r_face][cidx];

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            o_pos_x    <= r_wx + 26'(corner[2]);
            o_pos_y    <= {2'b00, r_y} - 10'd1 + 10'(corner[1]);
            o_pos_z    <= r_wz + 26'(corner[0]);
            o_tex_u    <= {1'b0, ardata[15:0]} + (TEX_U_HI[cidx] ? TEX_HI : TEX_LO);
            o_tex_v    <= {1'b0, ardata[31:16]} + (TEX_V_HI[cidx] ? TEX_HI : TEX_LO);
            o_face_dir <= r_face;
            o_last     <= face_done && (rem == 6'd0);
        end
    end

    a_emit_face_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_mask[r_face] && r_k <= 3'd5))
        else $error("emitting a face that is not exposed");
    a_no_pop_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> (!pop && !out_load))
        else $error("work started during store clearing");
    a_nbr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_NBR) |-> (r_cnt <= 3'd5))
        else $error("neighbor counter out of range");
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_load && face_done && rem == 6'd0) |=> (r_state == ST_IDLE))
        else $error("sequencer did not finish after the last vertex");
endmodule
`default_nettype wire

[design/voxel_face_culling_mesher_top.sv]
// Top level of the voxel face-culling mesher: front queue plus back sequencer.
// Depends on vfcm_pkg, vfcm_front, vfcm_back and vfcm_ram.
`default_nettype none
// After reset the block clears its voxel store, one entry per cycle, for all
// CHUNK_WIDTH*CHUNK_WIDTH*CHUNK_HEIGHT entries (65536 by default) and accepts no
// item meanwhile; configuration writes are taken at any time. A mesh item ends
// after the center read when the voxel is air; otherwise it tests the six
// neighbors and emits six vertices per exposed face, none when it is fully hidden,
// its pace set by the one read port of the voxel store, which tests the center
// and six neighbors one per cycle, and by one vertex transfer per cycle on the
// output while the receiver is ready. A two-entry queue lets new items be taken
// while a mesh item is still in progress.
module voxel_face_culling_mesher_top import vfcm_pkg::*; #(
    parameter int CHUNK_WIDTH  = 16,
    parameter int CHUNK_HEIGHT = 256,
    parameter int BLOCK_TYPES  = 256
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_idx,
    input  wire logic [20:0] i_cfg_wdata,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [1:0]  i_action,
    input  wire logic [3:0]  i_voxel_x,
    input  wire logic [7:0]  i_voxel_y,
    input  wire logic [3:0]  i_voxel_z,
    input  wire logic [7:0]  i_block_id,
    input  wire logic [2:0]  i_face_select,
    input  wire logic [15:0] i_atlas_u,
    input  wire logic [15:0] i_atlas_v,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [25:0]      o_pos_x,
    output logic [9:0]       o_pos_y,
    output logic [25:0]      o_pos_z,
    output logic [16:0]      o_tex_u,
    output logic [16:0]      o_tex_v,
    output logic [2:0]       o_face_dir,
    output logic             o_last
);
    t_back_stat stat;
    t_item      item;
    logic       item_valid;

    vfcm_front #(
        .CHUNK_WIDTH(CHUNK_WIDTH), .CHUNK_HEIGHT(CHUNK_HEIGHT), .BLOCK_TYPES(BLOCK_TYPES)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
        .i_action(i_action), .i_voxel_x(i_voxel_x), .i_voxel_y(i_voxel_y),
        .i_voxel_z(i_voxel_z), .i_block_id(i_block_id), .i_face_select(i_face_select),
        .i_atlas_u(i_atlas_u), .i_atlas_v(i_atlas_v), .i_stat(stat),
        .o_item_valid(item_valid), .o_item(item)
    );

    vfcm_back #(
        .CHUNK_WIDTH(CHUNK_WIDTH), .CHUNK_HEIGHT(CHUNK_HEIGHT), .BLOCK_TYPES(BLOCK_TYPES)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata), .i_item_valid(item_valid), .i_item(item),
        .o_stat(stat), .o_valid(o_valid), .i_ready(i_ready), .o_pos_x(o_pos_x),
        .o_pos_y(o_pos_y), .o_pos_z(o_pos_z), .o_tex_u(o_tex_u), .o_tex_v(o_tex_v),
        .o_face_dir(o_face_dir), .o_last(o_last)
    );
endmodule
`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the voxel face-culling mesher top level.
// Depends on vfcm_pkg and voxel_face_culling_mesher_top, and through it on the rest of the design.
`default_nettype none
module tb;
    import vfcm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]  act;
        logic [3:0]  x;
        logic [7:0]  y;
        logic [3:0]  z;
        logic [7:0]  id;
        logic [2:0]  face;
        logic [15:0] u;
        logic [15:0] v;
    } vox_item_t;

    typedef struct packed {
        logic [25:0] px;
        logic [9:0]  py;
        logic [25:0] pz;
        logic [16:0] tu;
        logic [16:0] tv;
        logic [2:0]  fd;
        logic        lst;
    } vertex_t;

    localparam int NBR_STEP [6][3] = '{
        '{0, 0, 1}, '{0, 0, -1}, '{0, 1, 0}, '{0, -1, 0}, '{-1, 0, 0}, '{1, 0, 0}
    };
    localparam int QUAD [6][4][3] = '{
        '{'{0, -1, 1}, '{1, -1, 1}, '{1, 0, 1}, '{0, 0, 1}},
        '{'{1, -1, 0}, '{0, -1, 0}, '{0, 0, 0}, '{1, 0, 0}},
        '{'{0, 0, 1}, '{1, 0, 1}, '{1, 0, 0}, '{0, 0, 0}},
        '{'{0, -1, 0}, '{1, -1, 0}, '{1, -1, 1}, '{0, -1, 1}},
        '{'{0, -1, 0}, '{0, -1, 1}, '{0, 0, 1}, '{0, 0, 0}},
        '{'{1, -1, 1}, '{1, -1, 0}, '{1, 0, 0}, '{1, 0, 1}}
    };
    localparam int TRI [6] = '{0, 1, 2, 0, 2, 3};
    localparam int UHI [4] = '{0, 1, 1, 0};
    localparam int VHI [4] = '{0, 0, 1, 1};
    localparam int TILE = 4096;
    localparam int EPS  = 250;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic        i_cfg_idx = CFG_ORIGIN_X;
    logic [20:0] i_cfg_wdata = '0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_action = ACT_WVOX;
    logic [3:0]  i_voxel_x = '0;
    logic [7:0]  i_voxel_y = '0;
    logic [3:0]  i_voxel_z = '0;
    logic [7:0]  i_block_id = '0;
    logic [2:0]  i_face_select = '0;
    logic [15:0] i_atlas_u = '0;
    logic [15:0] i_atlas_v = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [25:0] o_pos_x;
    logic [9:0]  o_pos_y;
    logic [25:0] o_pos_z;
    logic [16:0] o_tex_u;
    logic [16:0] o_tex_v;
    logic [2:0]  o_face_dir;
    logic        o_last;

    voxel_face_culling_mesher_top dut (.*);

    always #5 i_clk = ~i_clk;

    // Predictor state.
    logic [7:0]  voxel_ids [65536];
    logic [31:0] atlas_rows [1536];
    logic [20:0] origin_x = '0;
    logic [20:0] origin_z = '0;

    vox_item_t pending_items[$];
    vertex_t   vertex_q[$];
    int errors = 0;
    int items_taken = 0;
    int vertices_seen = 0;
    int meshes_taken = 0;

    // Generator bookkeeping, kept apart from the predictor since it runs ahead.
    bit   row_written [1536];
    bit   id_ready [256];
    int   ready_ids[$];
    bit   tx_burst = 0;
    bit   rx_burst = 0;
    logic hold_go = 1'b0;

    initial begin
        for (int i = 0; i < 65536; i++) voxel_ids[i] = '0;
        for (int i = 0; i < 1536; i++) atlas_rows[i] = '0;
    end

    function automatic logic [7:0] vox_at(int x, int y, int z);
        if (x < 0 || x > 15 || y < 0 || y > 255 || z < 0 || z > 15) return 8'd0;
        return voxel_ids[x + z * 16 + y * 256];
    endfunction

    task automatic predict_item(input vox_item_t it);
        int wx, wz, ix, iy, iz, c, first;
        logic [7:0]  blk;
        logic [31:0] ent;
        vertex_t vtx;
        ix = it.x;
        iy = it.y;
        iz = it.z;
        items_taken++;
        if (it.act == ACT_WVOX) begin
            voxel_ids[ix + iz * 16 + iy * 256] = it.id;
        end else if (it.act == ACT_WATL) begin
            if (it.face < 6) atlas_rows[it.id * 6 + it.face] = {it.v, it.u};
        end else if (it.act == ACT_MESH) begin
            meshes_taken++;
            blk = vox_at(ix, iy, iz);
            if (blk != 0) begin
                wx = $signed(origin_x) * 16 + ix;
                wz = $signed(origin_z) * 16 + iz;
                first = vertex_q.size();
                for (int f = 0; f < 6; f++) begin
                    if (vox_at(ix + NBR_STEP[f][0], iy + NBR_STEP[f][1],
                               iz + NBR_STEP[f][2]) == 0) begin
                        ent = atlas_rows[blk * 6 + f];
                        for (int k = 0; k < 6; k++) begin
                            c = TRI[k];
                            vtx.px  = 26'(wx + QUAD[f][c][0]);
                            vtx.py  = 10'(iy + QUAD[f][c][1]);
                            vtx.pz  = 26'(wz + QUAD[f][c][2]);
                            vtx.tu  = 17'(ent[15:0]) + 17'(UHI[c] ? TILE - EPS : EPS);
                            vtx.tv  = 17'(ent[31:16]) + 17'(VHI[c] ? TILE - EPS : EPS);
                            vtx.fd  = 3'(f);
                            vtx.lst = 1'b0;
                            vertex_q = {vertex_q, vtx};
                        end
                    end
                end
                if (vertex_q.size() > first) vertex_q[vertex_q.size() - 1].lst = 1'b1;
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("%0t: vertex %0d %s got %0h expected %0h",
                 $realtime, vertices_seen, what, got, want);
    endtask

    // Sender: one nonblocking update per signal per edge.
    int tx_gap = 0;
    always @(posedge i_clk) begin
        vox_item_t nxt;
        if (i_rst_n) begin
            if (i_valid && o_ready) predict_item({i_action, i_voxel_x, i_voxel_y,
                i_voxel_z, i_block_id, i_face_select, i_atlas_u, i_atlas_v});
            if (!(i_valid && !o_ready)) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    nxt = pending_items.pop_front();
                    i_action      <= nxt.act;
                    i_voxel_x     <= nxt.x;
                    i_voxel_y     <= nxt.y;
                    i_voxel_z     <= nxt.z;
                    i_block_id    <= nxt.id;
                    i_face_select <= nxt.face;
                    i_atlas_u     <= nxt.u;
                    i_atlas_v     <= nxt.v;
                    i_valid       <= 1'b1;
                    tx_gap        <= tx_burst ? 0 : $urandom_range(0, 6);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver with random stalls and one long hold-off.
    int  rx_wait = 0;
    bit  hold_done = 0;
    always @(posedge i_clk) begin
        vertex_t want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                if (vertex_q.size() == 0) begin
                    report_mismatch("unexpected transfer", 32'(o_pos_x), 32'd0);
                end else begin
                    want = vertex_q.pop_front();
                    if (o_pos_x !== want.px) report_mismatch("pos_x", 32'(o_pos_x), 32'(want.px));
                    if (o_pos_y !== want.py) report_mismatch("pos_y", 32'(o_pos_y), 32'(want.py));
                    if (o_pos_z !== want.pz) report_mismatch("pos_z", 32'(o_pos_z), 32'(want.pz));
                    if (o_tex_u !== want.tu) report_mismatch("tex_u", 32'(o_tex_u), 32'(want.tu));
                    if (o_tex_v !== want.tv) report_mismatch("tex_v", 32'(o_tex_v), 32'(want.tv));
                    if (o_face_dir !== want.fd)
                        report_mismatch("face_dir", 32'(o_face_dir), 32'(want.fd));
                    if (o_last !== want.lst) report_mismatch("last", 32'(o_last), 32'(want.lst));
                end
                vertices_seen++;
            end
            if (hold_go && !hold_done) begin
                hold_done = 1;
                rx_wait = 400;
                i_ready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                i_ready <= (rx_wait == 0);
            end else if (o_valid && i_ready) begin
                rx_wait = rx_burst ? 0 : $urandom_range(0, 6);
                i_ready <= (rx_wait == 0);
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    function automatic void add_item(input logic [1:0] act, input int x, input int y,
                                     input int z, input int id, input int face,
                                     input int u, input int v);
        vox_item_t it;
        bit full;
        it = {act, 4'(x), 8'(y), 4'(z), 8'(id), 3'(face), 16'(u), 16'(v)};
        pending_items = {pending_items, it};
        if (act == ACT_WATL && face < 6) begin
            row_written[id * 6 + face] = 1;
            full = 1;
            for (int f = 0; f < 6; f++) full &= row_written[id * 6 + f];
            if (full && !id_ready[id]) begin
                id_ready[id] = 1;
                ready_ids = {ready_ids, id};
            end
        end
    endfunction

    function automatic int pick_coord(input int centre, input int hi);
        int c;
        c = centre + $urandom_range(0, 2) - 1;
        return c < 0 ? 0 : (c > hi ? hi : c);
    endfunction

    function automatic int pick_edge(input int hi);
        case ($urandom_range(0, 3))
            0: return 0;
            1: return hi;
            default: return $urandom_range(0, hi);
        endcase
    endfunction

    // Mostly writes and meshes clustered in a small box so that faces get hidden.
    function automatic void build_phase(input int n);
        int fx, fy, fz, fresh, r, id;
        fx = pick_edge(15);
        fy = pick_edge(255);
        fz = pick_edge(15);
        fresh = $urandom_range(2, 254);
        for (int f = 0; f < 6; f++)
            add_item(ACT_WATL, 0, 0, 0, fresh, f, $urandom, $urandom);
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                id = ($urandom_range(0, 99) < 85) ?
                     ready_ids[$urandom_range(0, ready_ids.size() - 1)] : 0;
                add_item(ACT_WVOX, pick_coord(fx, 15), pick_coord(fy, 255),
                         pick_coord(fz, 15), id, $urandom_range(0, 7), $urandom, $urandom);
            end else if (r < 75) begin
                add_item(ACT_MESH, pick_coord(fx, 15), pick_coord(fy, 255),
                         pick_coord(fz, 15), $urandom_range(0, 255), $urandom_range(0, 7),
                         $urandom, $urandom);
            end else if (r < 88) begin
                id = ($urandom_range(0, 1) == 0) ?
                     ready_ids[$urandom_range(0, ready_ids.size() - 1)] : $urandom_range(0, 255);
                add_item(ACT_WATL, $urandom_range(0, 15), $urandom_range(0, 255),
                         $urandom_range(0, 15), id, $urandom_range(0, 7), $urandom, $urandom);
            end else if (r < 93) begin
                // Unused action code; the block drops it.
                add_item(2'd3, $urandom_range(0, 15), $urandom_range(0, 255),
                         $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 7),
                         $urandom, $urandom);
            end else begin
                add_item(($urandom_range(0, 1) == 0) ? ACT_MESH : ACT_WVOX,
                         $urandom_range(0, 15), $urandom_range(0, 255), $urandom_range(0, 15),
                         ready_ids[$urandom_range(0, ready_ids.size() - 1)],
                         $urandom_range(0, 7), $urandom, $urandom);
            end
        end
    endfunction

    task automatic wait_drained();
        do @(posedge i_clk); while (pending_items.size() > 0 || i_valid || vertex_q.size() > 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic write_origin(input logic [20:0] ox, input logic [20:0] oz);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= CFG_ORIGIN_X;
        i_cfg_wdata <= ox;
        origin_x = ox;
        @(posedge i_clk);
        i_cfg_idx   <= CFG_ORIGIN_Z;
        i_cfg_wdata <= oz;
        origin_z = oz;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [20:0] ox_set [5];
        logic [20:0] oz_set [5];
        ox_set = '{21'h0FFFFF, 21'h100000, 21'h000000, 21'h1FFFFF, 21'(0)};
        oz_set = '{21'h100000, 21'h0FFFFF, 21'h1FFFFF, 21'h000001, 21'(0)};
        ox_set[4] = 21'($urandom);
        oz_set[4] = 21'($urandom);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_origin(21'd0, 21'd0);

        // Directed: table extremes, corner voxels, culling, air, ignored items.
        for (int f = 0; f < 6; f++) add_item(ACT_WATL, 0, 0, 0, 1, f,
            f[0] ? 16'hFFFF : 16'h0000, f[1] ? 16'hFFFF : 16'h0000);
        for (int f = 0; f < 6; f++) add_item(ACT_WATL, 15, 255, 15, 255, f,
            f[0] ? 16'h0000 : 16'hFFFF, f[1] ? 16'h0000 : 16'hFFFF);
        add_item(ACT_WATL, 0, 0, 0, 1, 7, 16'h1234, 16'h5678);
        add_item(ACT_WVOX, 0, 0, 0, 1, 0, 0, 0);
        add_item(ACT_MESH, 0, 0, 0, 0, 0, 0, 0);
        add_item(ACT_WVOX, 15, 255, 15, 255, 0, 0, 0);
        add_item(ACT_MESH, 15, 255, 15, 0, 0, 0, 0);
        add_item(ACT_WVOX, 1, 0, 0, 1, 0, 0, 0);
        add_item(ACT_WVOX, 0, 1, 0, 255, 0, 0, 0);
        add_item(ACT_MESH, 0, 0, 0, 0, 0, 0, 0);
        add_item(ACT_MESH, 5, 5, 5, 0, 0, 0, 0);
        add_item(2'd3, 0, 0, 0, 1, 0, 0, 0);
        add_item(ACT_WVOX, 1, 0, 0, 0, 0, 0, 0);
        add_item(ACT_MESH, 1, 0, 0, 0, 0, 0, 0);
        wait_drained();

        for (int p = 0; p < 5; p++) begin
            write_origin(ox_set[p], oz_set[p]);
            tx_burst = (p == 1);
            rx_burst = (p == 3);
            build_phase(46);
            if (p == 2) begin
                tx_burst = 1;
                hold_go <= 1'b1;
            end
            wait_drained();
        end

        $display("Run covered %0d items, %0d mesh requests and %0d vertices over six origins.",
                 items_taken, meshes_taken, vertices_seen);
        if (errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("Timed out with %0d vertices outstanding.", vertex_q.size());
        $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire
